// File: rtl/core/kce_pkg.sv
// Shared widths, register indexes and defaults of the k-combination enumerator.
package kce_pkg;

   localparam int MAX_ELEMENTS_DEF = 64;

   localparam int ELEM_W    = 6;
   localparam int CFG_W     = 7;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] REG_SET_SIZE    = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_SUBSET_SIZE = CSR_IDX_W'(1);

   localparam logic [CFG_W-1:0] SET_SIZE_RST    = CFG_W'(64);
   localparam logic [CFG_W-1:0] SUBSET_SIZE_RST = CFG_W'(1);

endpackage

// File: rtl/core/kce_if.sv
// Valid/ready channel interfaces for requests, results and register writes.
interface kce_req_if import kce_pkg::*; ();
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink   (input valid, input restart, output ready);
endinterface

interface kce_rsp_if import kce_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ELEM_W-1:0] element;
   logic              last_of_subset;
   logic              exhausted;

   modport source (output valid, output element, output last_of_subset, output exhausted,
                   input ready);
   modport sink   (input valid, input element, input last_of_subset, input exhausted,
                   output ready);
endinterface

interface kce_csr_if import kce_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CFG_W-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/k_combination_enumerator_unit.sv
// Lexicographic k-combination enumerator built around one subset memory.
// A request's first result passes through the read stage and the result register
// before it appears on the result port.
// Results leave at one per cycle while the result port is ready, then the memory
// is refilled from the pivot position up to position k-1, one write per refilled
// position through the single memory write port; no new request is taken until then.
// Reset is synchronous; afterwards a restart request is needed before any subset.
module k_combination_enumerator_unit import kce_pkg::*; #(
   parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   kce_req_if.sink    req_bus,
   kce_rsp_if.source  rsp_bus,
   kce_csr_if.sink    csr_bus
);

   localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
   localparam logic [CFG_W-1:0] MAX_N = CFG_W'(MAX_ELEMENTS);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_EMIT  = 3'd1;
   localparam logic [2:0] ST_EXH   = 3'd2;
   localparam logic [2:0] ST_DRAIN = 3'd3;
   localparam logic [2:0] ST_FILL  = 3'd4;

   logic [ELEM_W-1:0] mem [MAX_ELEMENTS];
   logic [ELEM_W-1:0] rd_data_ff;

   logic [2:0]       state_ff;
   logic [CFG_W-1:0] set_size_ff;
   logic [CFG_W-1:0] subset_size_ff;
   logic             done_ff;
   logic             rewind_ff;
   logic [AW-1:0]    iss_ff;

   logic             s1_valid_ff;
   logic [AW-1:0]    s1_idx_ff;
   logic             s1_rewind_ff;
   logic             s1_last_ff;
   logic             s1_exh_ff;

   logic              piv_found_ff;
   logic [AW-1:0]     piv_idx_ff;
   logic [ELEM_W-1:0] piv_val_ff;
   logic [AW-1:0]     fill_addr_ff;
   logic [ELEM_W-1:0] fill_val_ff;

   logic              rsp_valid_ff;
   logic [ELEM_W-1:0] rsp_element_ff;
   logic              rsp_last_ff;
   logic              rsp_exh_ff;

   logic [CFG_W-1:0]  n_eff;
   logic              k_ok;
   logic [AW-1:0]     k_m1;
   logic              req_xfer;
   logic              out_load;
   logic              s1_free;
   logic              issue;
   logic [ELEM_W-1:0] s1_elem;
   logic [CFG_W-1:0]  grow_limit;
   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   logic [ELEM_W-1:0] mem_wdata;

   assign n_eff = (set_size_ff > MAX_N) ? MAX_N : set_size_ff;
   assign k_ok  = (subset_size_ff != '0) && (subset_size_ff <= n_eff);
   assign k_m1  = AW'(subset_size_ff - CFG_W'(1));

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_xfer      = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   assign out_load = s1_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign s1_free  = !s1_valid_ff || out_load;
   assign issue    = (state_ff == ST_EMIT) && s1_free;

   // After a restart the subset is 0..k-1, so the value is the position itself.
   assign s1_elem    = s1_rewind_ff ? ELEM_W'(s1_idx_ff) : rd_data_ff;
   // A position can still grow while its value is below n-k plus its position.
   assign grow_limit = n_eff - subset_size_ff + CFG_W'(s1_idx_ff);

   assign mem_we    = (issue && rewind_ff) || (state_ff == ST_FILL);
   assign mem_waddr = (state_ff == ST_FILL) ? fill_addr_ff : iss_ff;
   assign mem_wdata = (state_ff == ST_FILL) ? fill_val_ff : ELEM_W'(iss_ff);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (issue) begin
         rd_data_ff <= mem[iss_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         set_size_ff    <= SET_SIZE_RST;
         subset_size_ff <= SUBSET_SIZE_RST;
         done_ff        <= 1'b1;
         rewind_ff      <= 1'b0;
         iss_ff         <= '0;
         s1_valid_ff    <= 1'b0;
         piv_found_ff   <= 1'b0;
      end else begin
         if (csr_bus.valid && csr_bus.ready) begin
            if (csr_bus.index == REG_SET_SIZE) begin
               set_size_ff <= csr_bus.data;
               done_ff     <= 1'b1;
            end else if (csr_bus.index == REG_SUBSET_SIZE) begin
               subset_size_ff <= csr_bus.data;
               done_ff        <= 1'b1;
            end
         end

         if (out_load) begin
            s1_valid_ff <= 1'b0;
            if (!s1_exh_ff && ({1'b0, s1_elem} < grow_limit)) begin
               piv_found_ff <= 1'b1;
               piv_idx_ff   <= s1_idx_ff;
               piv_val_ff   <= s1_elem;
            end
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_xfer) begin
                  piv_found_ff <= 1'b0;
                  if (!k_ok || (!req_bus.restart && done_ff)) begin
                     done_ff  <= 1'b1;
                     state_ff <= ST_EXH;
                  end else begin
                     done_ff   <= 1'b0;
                     rewind_ff <= req_bus.restart;
                     iss_ff    <= '0;
                     state_ff  <= ST_EMIT;
                  end
               end
            end
            ST_EMIT: begin
               if (issue) begin
                  s1_valid_ff  <= 1'b1;
                  s1_idx_ff    <= iss_ff;
                  s1_rewind_ff <= rewind_ff;
                  s1_last_ff   <= (iss_ff == k_m1);
                  s1_exh_ff    <= 1'b0;
                  if (iss_ff == k_m1) begin
                     state_ff <= ST_DRAIN;
                  end else begin
                     iss_ff <= iss_ff + AW'(1);
                  end
               end
            end
            ST_EXH: begin
               if (s1_free) begin
                  s1_valid_ff  <= 1'b1;
                  s1_idx_ff    <= '0;
                  s1_rewind_ff <= 1'b1;
                  s1_last_ff   <= 1'b1;
                  s1_exh_ff    <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            ST_DRAIN: begin
               // The pivot is final once the last element has left the read stage.
               if (!s1_valid_ff) begin
                  if (piv_found_ff) begin
                     fill_addr_ff <= piv_idx_ff;
                     fill_val_ff  <= piv_val_ff + ELEM_W'(1);
                     state_ff     <= ST_FILL;
                  end else begin
                     done_ff  <= 1'b1;
                     state_ff <= ST_IDLE;
                  end
               end
            end
            ST_FILL: begin
               if (fill_addr_ff == k_m1) begin
                  state_ff <= ST_IDLE;
               end else begin
                  fill_addr_ff <= fill_addr_ff + AW'(1);
                  fill_val_ff  <= fill_val_ff + ELEM_W'(1);
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_element_ff <= s1_elem;
         rsp_last_ff    <= s1_last_ff;
         rsp_exh_ff     <= s1_exh_ff;
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.element        = rsp_element_ff;
   assign rsp_bus.last_of_subset = rsp_last_ff;
   assign rsp_bus.exhausted      = rsp_exh_ff;

endmodule

// File: verif/tb_k_combination_enumerator_unit.sv
// Self-checking testbench of the k-combination enumerator with a subset-tracking scoreboard.
`timescale 1ns / 100ps

module tb_k_combination_enumerator_unit import kce_pkg::*; ();

   localparam int MAX_ELEMENTS = MAX_ELEMENTS_DEF;
   // Longest stretch the block may spend on one request after its last result.
   localparam int DRAIN_CYCLES = 2 * MAX_ELEMENTS + 8;
   localparam int RANDOM_ITEMS = 125;

   // Indexes that decode to no register.
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED_2 = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED_3 = CSR_IDX_W'(3);

   typedef struct packed {
      logic [ELEM_W-1:0] element;
      logic              last_of_subset;
      logic              exhausted;
   } kce_result_type;

   class subset_scoreboard_type;
      logic [CFG_W-1:0]  set_size;
      logic [CFG_W-1:0]  subset_size;
      logic [ELEM_W-1:0] subset[MAX_ELEMENTS];
      bit                awaiting_restart;
      kce_result_type    expected_elements[$];
      int                error_count;

      function new();
         set_size         = SET_SIZE_RST;
         subset_size      = SUBSET_SIZE_RST;
         awaiting_restart = 1'b1;
         error_count      = 0;
         rewind();
      endfunction

      function void rewind();
         for (int i = 0; i < MAX_ELEMENTS; i++) subset[i] = ELEM_W'(i);
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] index, logic [CFG_W-1:0] data);
         case (index)
            REG_SET_SIZE: begin
               set_size         = data;
               awaiting_restart = 1'b1;
            end
            REG_SUBSET_SIZE: begin
               subset_size      = data;
               awaiting_restart = 1'b1;
            end
            default: ;
         endcase
      endfunction

      // Moves to the lexicographic successor; returns 0 when the current subset is the last.
      function bit step_forward(int n, int k);
         for (int i = k - 1; i >= 0; i--) begin
            if (int'(subset[i]) < n - (k - i)) begin
               subset[i] = subset[i] + 1'b1;
               for (int j = i + 1; j < k; j++) subset[j] = subset[j-1] + 1'b1;
               return 1'b1;
            end
         end
         return 1'b0;
      endfunction

      function void note_request(logic restart);
         int             n;
         int             k;
         bit             k_ok;
         kce_result_type r;
         n    = (int'(set_size) > MAX_ELEMENTS) ? MAX_ELEMENTS : int'(set_size);
         k    = int'(subset_size);
         k_ok = (k != 0) && (k <= n);
         if (restart) begin
            if (k_ok) begin
               rewind();
               awaiting_restart = 1'b0;
            end else begin
               awaiting_restart = 1'b1;
            end
         end
         if (awaiting_restart || !k_ok) begin
            awaiting_restart = 1'b1;
            r.element        = '0;
            r.last_of_subset = 1'b1;
            r.exhausted      = 1'b1;
            expected_elements.push_back(r);
            return;
         end
         for (int i = 0; i < k; i++) begin
            r.element        = subset[i];
            r.last_of_subset = (i == k - 1);
            r.exhausted      = 1'b0;
            expected_elements.push_back(r);
         end
         if (!step_forward(n, k)) awaiting_restart = 1'b1;
      endfunction

      function void check_result(logic [ELEM_W-1:0] element, logic last_of_subset,
                                 logic exhausted);
         kce_result_type want;
         if (expected_elements.size() == 0) begin
            $error("unexpected result: element=%0d last_of_subset=%0b exhausted=%0b",
                   element, last_of_subset, exhausted);
            error_count++;
            return;
         end
         want = expected_elements.pop_front();
         if (element !== want.element) begin
            $error("element: expected %0d, actual %0d", want.element, element);
            error_count++;
         end
         if (last_of_subset !== want.last_of_subset) begin
            $error("last_of_subset: expected %0b, actual %0b", want.last_of_subset,
                   last_of_subset);
            error_count++;
         end
         if (exhausted !== want.exhausted) begin
            $error("exhausted: expected %0b, actual %0b", want.exhausted, exhausted);
            error_count++;
         end
      endfunction

      function int pending();
         return expected_elements.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   kce_req_if req_bus ();
   kce_rsp_if rsp_bus ();
   kce_csr_if csr_bus ();

   k_combination_enumerator_unit #(.MAX_ELEMENTS(MAX_ELEMENTS)) DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   subset_scoreboard_type sb = new();
   bit no_idle = 1'b0;
   int rsp_hold = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("[k_combination_enumerator_unit] ERROR");
      $finish;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 9);
      if (r < 5) return 0;
      if (r < 9) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   initial rsp_bus.ready = 1'b0;

   always @(posedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
         if (!no_idle && $urandom_range(0, 5) == 0) rsp_hold = pick_gap();
      end
   end

   // Every transfer is observed here, on the same edge the block sees it.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) sb.note_request(req_bus.restart);
         if (csr_bus.valid && csr_bus.ready) sb.write_reg(csr_bus.index, csr_bus.data);
         if (rsp_bus.valid && rsp_bus.ready)
            sb.check_result(rsp_bus.element, rsp_bus.last_of_subset, rsp_bus.exhausted);
      end
   end

   task automatic send_request(logic restart);
      int gap;
      req_bus.valid   <= 1'b1;
      req_bus.restart <= restart;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] index, logic [CFG_W-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data  <= data;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // Holds the sender back until every predicted result has arrived and the block has settled.
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_config(int n, int k);
      if ($urandom_range(0, 1) == 0) begin
         write_reg(REG_SET_SIZE, CFG_W'(n));
         write_reg(REG_SUBSET_SIZE, CFG_W'(k));
      end else begin
         write_reg(REG_SUBSET_SIZE, CFG_W'(k));
         write_reg(REG_SET_SIZE, CFG_W'(n));
      end
   endtask

   task automatic write_unused();
      write_reg(($urandom_range(0, 1) == 0) ? REG_UNUSED_2 : REG_UNUSED_3,
                CFG_W'($urandom_range(0, 127)));
   endtask

   initial begin
      int random_items;
      int cfg_n;
      int cfg_k;
      int count;
      int pick;
      random_items    = 0;
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.restart = 1'b0;
      csr_bus.valid   = 1'b0;
      csr_bus.index   = '0;
      csr_bus.data    = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed part. Right after reset the block waits for a restart.
      send_request(1'b0);
      send_request(1'b1);
      send_request(1'b0);
      wait_idle();
      write_reg(REG_SET_SIZE, CFG_W'(4));
      write_reg(REG_SUBSET_SIZE, CFG_W'(2));
      send_request(1'b1);
      repeat (6) send_request(1'b0);
      send_request(1'b1);
      wait_idle();
      // Writes to unused indexes must not disturb the sequence in progress.
      write_reg(REG_UNUSED_2, CFG_W'(127));
      write_reg(REG_UNUSED_3, CFG_W'(0));
      send_request(1'b0);
      wait_idle();
      write_reg(REG_SUBSET_SIZE, CFG_W'(2));
      send_request(1'b0);
      wait_idle();
      write_reg(REG_SUBSET_SIZE, CFG_W'(0));
      send_request(1'b1);
      wait_idle();
      set_config(0, 1);
      send_request(1'b1);
      wait_idle();
      set_config(127, 64);
      send_request(1'b1);
      send_request(1'b0);
      wait_idle();
      set_config(64, 63);
      send_request(1'b1);
      send_request(1'b0);
      send_request(1'b0);
      wait_idle();
      set_config(3, 4);
      send_request(1'b1);
      wait_idle();
      set_config(1, 1);
      send_request(1'b1);
      send_request(1'b0);

      // Random phases: mostly small sets so that sequences run out and wrap around.
      while (random_items < RANDOM_ITEMS) begin
         wait_idle();
         pick = $urandom_range(0, 19);
         case (pick)
            0: begin
               cfg_n = ($urandom_range(0, 1) == 0) ? 64 : 127;
               cfg_k = $urandom_range(60, 64);
            end
            1: begin
               cfg_n = $urandom_range(0, 127);
               cfg_k = $urandom_range(0, 127);
            end
            2: begin
               cfg_n = $urandom_range(0, 10);
               cfg_k = 0;
            end
            3: begin
               cfg_n = $urandom_range(0, 10);
               cfg_k = cfg_n + 1;
            end
            4: begin
               cfg_n = $urandom_range(60, 64);
               cfg_k = $urandom_range(1, 2);
            end
            default: begin
               cfg_n = $urandom_range(1, 8);
               cfg_k = $urandom_range(1, cfg_n);
            end
         endcase
         if ($urandom_range(0, 3) == 0) write_unused();
         set_config(cfg_n, cfg_k);
         no_idle = ($urandom_range(0, 5) == 0);
         count   = $urandom_range(6, 20);
         for (int i = 0; i < count; i++) begin
            if (i == 0) send_request($urandom_range(0, 9) != 0);
            else send_request($urandom_range(0, 11) == 0);
            random_items++;
            if ($urandom_range(0, 19) == 0) begin
               wait_idle();
               pick = $urandom_range(0, 2);
               if (pick == 0) write_unused();
               // Rewriting a register mid-sequence forces a fresh restart.
               else if (pick == 1) write_reg(REG_SET_SIZE, CFG_W'(cfg_n));
            end
         end
         no_idle = 1'b0;
      end

      wait_idle();
      if (sb.error_count == 0 && sb.pending() == 0) begin
         $display("[k_combination_enumerator_unit] OK");
      end else begin
         $display("[k_combination_enumerator_unit] ERROR");
      end
      $finish;
   end

endmodule

// File: k_combination_enumerator_unit.f
rtl/core/kce_pkg.sv
rtl/core/kce_if.sv
rtl/core/k_combination_enumerator_unit.sv
verif/tb_k_combination_enumerator_unit.sv
